>>> hdl/flp_pkg.sv
`default_nettype none
package flp_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int STATE_WIDTH  = 24;
  localparam int CUTOFF_MAX   = 8140;

  localparam int CUTOFF_W = 14;
  localparam int RES_W    = 16;
  localparam int FC_W     = $clog2(CUTOFF_MAX + 1);
  localparam int NSTAGES  = 4;
  localparam int STG_W    = $clog2(NSTAGES);

  localparam int STATE_FRAC  = STATE_WIDTH - 5;
  localparam int SAMPLE_FRAC = SAMPLE_WIDTH - 1;
  localparam int FRAC_SHIFT  = STATE_FRAC - SAMPLE_FRAC;
  localparam int OUT_HALF    = 2 ** (FRAC_SHIFT - 1);

  localparam int COEF_FRAC = 16;
  localparam int Q16_ONE   = 65536;
  localparam int Q16_HALF  = 32768;
  localparam int COEF_03   = 19661;
  localparam int COEF_PT1  = 50412;
  localparam int FB_SHIFT  = 12;
  localparam int FB_HALF   = 2048;
  localparam int RES_MAX   = 4 * 4096;

  localparam int PT_DIV    = 7100;
  localparam int PT_BIAS   = 3550;
  localparam int RED_KNEE  = 3800;
  localparam int RED_DIV   = 8600;
  localparam int RED_BIAS  = 4300;
  localparam int RED_SHIFT = 12;

  localparam int MUL_AW = STATE_WIDTH + 2;
  localparam int MUL_BW = 18;
  localparam int MUL_PW = MUL_AW + MUL_BW + 1;
  localparam int MUL_CW = $clog2(MUL_BW);
  localparam int PTQ_W  = 18;

  localparam int DIV_DW = 30;
  localparam int DIV_VW = 14;
  localparam int DIV_CW = $clog2(DIV_DW);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_RED,
    ST_DIV_PT,
    ST_MUL_PT1,
    ST_MUL_FB,
    ST_MUL_PREV,
    ST_MUL_IN,
    ST_MUL_OUT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [MUL_AW-1:0] a;
    logic signed [MUL_BW-1:0] b;
    logic signed [MUL_PW-1:0] c;
  } mul_req_t;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

endpackage
`default_nettype wire

>>> hdl/flp_if.sv
`default_nettype none
interface flp_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    action;
  logic signed [flp_pkg::SAMPLE_WIDTH-1:0] audio_in;
  logic [flp_pkg::CUTOFF_W-1:0]            cutoff_hz;
  logic signed [flp_pkg::RES_W-1:0]        resonance;

  modport source (output valid, action, audio_in, cutoff_hz, resonance, input ready);
  modport sink (input valid, action, audio_in, cutoff_hz, resonance, output ready);
endinterface

interface flp_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [flp_pkg::SAMPLE_WIDTH-1:0] audio_out;

  modport source (output valid, audio_out, input ready);
  modport sink (input valid, audio_out, output ready);
endinterface
`default_nettype wire

>>> hdl/flp_sdiv.sv
`default_nettype none
module flp_sdiv (
  input  logic                         clk,
  input  logic                         rst_n,
  input  flp_pkg::div_req_t            req,
  output logic                         done,
  output logic [flp_pkg::DIV_DW-1:0]   quot
);

  logic [flp_pkg::DIV_DW-1:0] dq_r, dq_nxt;
  logic [flp_pkg::DIV_VW-1:0] rem_r, rem_nxt;
  logic [flp_pkg::DIV_VW-1:0] dvs_r;
  logic [flp_pkg::DIV_CW-1:0] cnt_r;
  logic                       busy_r;
  logic                       done_r;
  logic [flp_pkg::DIV_VW:0]   trial;
  logic [flp_pkg::DIV_VW:0]   diff;
  logic                       ge;

  // One restoring step per cycle: the dividend shifts out at the top while
  // quotient bits shift in at the bottom of the same register.
  always_comb begin
    trial   = {rem_r, dq_r[flp_pkg::DIV_DW-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[flp_pkg::DIV_VW-1:0] : trial[flp_pkg::DIV_VW-1:0];
    dq_nxt  = {dq_r[flp_pkg::DIV_DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dq_r  <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
      cnt_r <= flp_pkg::DIV_CW'(flp_pkg::DIV_DW - 1);
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - flp_pkg::DIV_CW'(1);
    end
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule
`default_nettype wire

>>> hdl/flp_smul.sv
`default_nettype none
module flp_smul (
  input  logic                                clk,
  input  logic                                rst_n,
  input  flp_pkg::mul_req_t                   req,
  output logic                                done,
  output logic signed [flp_pkg::MUL_PW-1:0]   prod
);

  logic signed [flp_pkg::MUL_AW:0]   hi_r, hi_nxt;
  logic [flp_pkg::MUL_BW-1:0]        lo_r, lo_nxt;
  logic signed [flp_pkg::MUL_AW:0]   a_r;
  logic signed [flp_pkg::MUL_PW-1:0] c_r;
  logic signed [flp_pkg::MUL_PW-1:0] res_r;
  logic [flp_pkg::MUL_CW-1:0]        cnt_r;
  logic                              busy_r;
  logic                              fin_r;
  logic                              done_r;
  logic signed [flp_pkg::MUL_AW:0]   addend;
  logic signed [flp_pkg::MUL_AW:0]   sum;

  // The multiplier operand is consumed one bit per cycle from the bottom of
  // lo_r; its top bit carries negative weight.
  always_comb begin
    if (lo_r[0]) begin
      addend = (cnt_r == '0) ? -a_r : a_r;
    end else begin
      addend = '0;
    end
    sum    = hi_r + addend;
    hi_nxt = sum >>> 1;
    lo_nxt = {sum[0], lo_r[flp_pkg::MUL_BW-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      fin_r  <= busy_r && (cnt_r == '0);
      done_r <= fin_r;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      hi_r  <= '0;
      lo_r  <= req.b;
      a_r   <= {req.a[flp_pkg::MUL_AW-1], req.a};
      c_r   <= req.c;
      cnt_r <= flp_pkg::MUL_CW'(flp_pkg::MUL_BW - 1);
    end else if (busy_r) begin
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
      cnt_r <= cnt_r - flp_pkg::MUL_CW'(1);
    end
    if (fin_r) begin
      res_r <= c_r + $signed({hi_r, lo_r});
    end
  end

  assign done = done_r;
  assign prod = res_r;

endmodule
`default_nettype wire

>>> hdl/four_pole_ladder_lowpass.sv
// A filter request runs two 30-bit serial divisions and fourteen bit-serial 18-bit
// multiplications before its result; a clear goes straight to the output state.
// No new request is taken until the previous one has reached the output state.
// A new request is taken while the previous result still waits at the output.
// Reset (rst_n low, synchronous) zeroes all stage state and empties the output.
`default_nettype none
module four_pole_ladder_lowpass (
  input  logic       clk,
  input  logic       rst_n,
  flp_in_if.sink     in_ch,
  flp_out_if.source  out_ch
);

  localparam int SW = flp_pkg::STATE_WIDTH;
  localparam int PW = flp_pkg::MUL_PW;
  localparam int AW = flp_pkg::MUL_AW;
  localparam int BW = flp_pkg::MUL_BW;
  localparam int OW = flp_pkg::STATE_WIDTH + 1;

  function automatic logic signed [SW-1:0] sat_state(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi;
    logic signed [PW-1:0] lo;
    hi = {{(PW - SW + 1){1'b0}}, {(SW - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[SW-1:0];
    end else if (v < lo) begin
      return lo[SW-1:0];
    end
    return v[SW-1:0];
  endfunction

  function automatic logic signed [flp_pkg::SAMPLE_WIDTH-1:0] sat_sample(
    input logic signed [OW-1:0] v);
    logic signed [OW-1:0] hi;
    logic signed [OW-1:0] lo;
    hi = {{(OW - flp_pkg::SAMPLE_WIDTH + 1){1'b0}}, {(flp_pkg::SAMPLE_WIDTH - 1){1'b1}}};
    lo = ~hi;
    if (v > hi) begin
      return hi[flp_pkg::SAMPLE_WIDTH-1:0];
    end else if (v < lo) begin
      return lo[flp_pkg::SAMPLE_WIDTH-1:0];
    end
    return v[flp_pkg::SAMPLE_WIDTH-1:0];
  endfunction

  flp_pkg::state_t state_r, state_nxt;
  logic            launch_r;
  logic [flp_pkg::STG_W-1:0] stage_r;

  logic signed [SW-1:0] pi_r [flp_pkg::NSTAGES];
  logic signed [SW-1:0] po_r [flp_pkg::NSTAGES];

  logic signed [flp_pkg::SAMPLE_WIDTH-1:0] x_r;
  logic [flp_pkg::FC_W-1:0]                fc_r;
  logic signed [flp_pkg::RES_W-1:0]        kc_r;
  logic [flp_pkg::PTQ_W-1:0]               ptq_r;
  logic signed [BW-1:0]                    pt1_r;
  logic signed [BW-1:0]                    npt_r;
  logic signed [SW-1:0]                    u_r;
  logic signed [AW-1:0]                    t_r;

  logic                                    out_valid_r;
  logic signed [flp_pkg::SAMPLE_WIDTH-1:0] out_data_r;

  logic in_ready;
  logic in_acc;
  logic out_free;

  flp_pkg::mul_req_t mul_req;
  flp_pkg::div_req_t div_req;
  logic                     mul_done;
  logic signed [PW-1:0]     mul_p;
  logic                     div_done;
  logic [flp_pkg::DIV_DW-1:0] div_quot;

  logic [flp_pkg::DIV_DW-1:0] red_dvd;
  logic [flp_pkg::DIV_DW-1:0] pt_dvd;
  logic signed [PW-1:0]       x_ext;
  logic signed [PW-1:0]       fb_diff;
  logic signed [PW-1:0]       p_sh;
  logic signed [AW-1:0]       p_lo;
  logic signed [AW-1:0]       t_new;
  logic signed [SW-1:0]       u_fb;
  logic signed [SW-1:0]       y_new;
  logic signed [OW-1:0]       out_rnd;

  flp_smul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .done  (mul_done),
    .prod  (mul_p)
  );

  flp_sdiv u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_acc   = in_ch.valid && in_ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    if (flp_pkg::DIV_DW'(fc_r) > flp_pkg::DIV_DW'(flp_pkg::RED_KNEE)) begin
      red_dvd = ((flp_pkg::DIV_DW'(fc_r) - flp_pkg::DIV_DW'(flp_pkg::RED_KNEE))
                 << flp_pkg::RED_SHIFT) + flp_pkg::DIV_DW'(flp_pkg::RED_BIAS);
    end else begin
      red_dvd = '0;
    end
    pt_dvd  = (flp_pkg::DIV_DW'(fc_r) << flp_pkg::COEF_FRAC)
              + flp_pkg::DIV_DW'(flp_pkg::PT_BIAS);
    x_ext   = PW'(x_r);
    fb_diff = (x_ext <<< flp_pkg::FRAC_SHIFT) - (mul_p >>> flp_pkg::FB_SHIFT);
    u_fb    = sat_state(fb_diff);
    p_sh    = mul_p >>> flp_pkg::COEF_FRAC;
    p_lo    = p_sh[AW-1:0];
    t_new   = AW'(u_r) + p_lo;
    y_new   = sat_state(p_sh);
    out_rnd = (OW'(po_r[flp_pkg::NSTAGES-1]) + OW'(flp_pkg::OUT_HALF))
              >>> flp_pkg::FRAC_SHIFT;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      flp_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_ch.action ? flp_pkg::ST_OUT : flp_pkg::ST_DIV_RED;
        end
      end
      flp_pkg::ST_DIV_RED: begin
        if (div_done) state_nxt = flp_pkg::ST_DIV_PT;
      end
      flp_pkg::ST_DIV_PT: begin
        if (div_done) state_nxt = flp_pkg::ST_MUL_PT1;
      end
      flp_pkg::ST_MUL_PT1: begin
        if (mul_done) state_nxt = flp_pkg::ST_MUL_FB;
      end
      flp_pkg::ST_MUL_FB: begin
        if (mul_done) state_nxt = flp_pkg::ST_MUL_PREV;
      end
      flp_pkg::ST_MUL_PREV: begin
        if (mul_done) state_nxt = flp_pkg::ST_MUL_IN;
      end
      flp_pkg::ST_MUL_IN: begin
        if (mul_done) state_nxt = flp_pkg::ST_MUL_OUT;
      end
      flp_pkg::ST_MUL_OUT: begin
        if (mul_done) begin
          if (stage_r == flp_pkg::STG_W'(flp_pkg::NSTAGES - 1)) begin
            state_nxt = flp_pkg::ST_OUT;
          end else begin
            state_nxt = flp_pkg::ST_MUL_PREV;
          end
        end
      end
      flp_pkg::ST_OUT: begin
        if (out_free) state_nxt = flp_pkg::ST_IDLE;
      end
      default: state_nxt = flp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mul_req  = '0;
    div_req  = '0;
    unique case (state_r)
      flp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
      end
      flp_pkg::ST_DIV_RED: begin
        div_req.start    = !launch_r;
        div_req.dividend = red_dvd;
        div_req.divisor  = flp_pkg::DIV_VW'(flp_pkg::RED_DIV);
      end
      flp_pkg::ST_DIV_PT: begin
        div_req.start    = !launch_r;
        div_req.dividend = pt_dvd;
        div_req.divisor  = flp_pkg::DIV_VW'(flp_pkg::PT_DIV);
      end
      flp_pkg::ST_MUL_PT1: begin
        mul_req.start = !launch_r;
        mul_req.a     = AW'(ptq_r);
        mul_req.b     = BW'(flp_pkg::COEF_PT1);
        mul_req.c     = PW'(flp_pkg::Q16_HALF);
      end
      flp_pkg::ST_MUL_FB: begin
        mul_req.start = !launch_r;
        mul_req.a     = AW'(po_r[flp_pkg::NSTAGES-1]);
        mul_req.b     = BW'(kc_r);
        mul_req.c     = PW'(flp_pkg::FB_HALF);
      end
      flp_pkg::ST_MUL_PREV: begin
        mul_req.start = !launch_r;
        mul_req.a     = AW'(pi_r[0]);
        mul_req.b     = BW'(flp_pkg::COEF_03);
        mul_req.c     = PW'(flp_pkg::Q16_HALF);
      end
      flp_pkg::ST_MUL_IN: begin
        mul_req.start = !launch_r;
        mul_req.a     = t_r;
        mul_req.b     = pt1_r;
        mul_req.c     = PW'(flp_pkg::Q16_HALF);
      end
      flp_pkg::ST_MUL_OUT: begin
        // The previous product still sits in the multiplier and is accumulated.
        mul_req.start = !launch_r;
        mul_req.a     = AW'(po_r[0]);
        mul_req.b     = npt_r;
        mul_req.c     = mul_p;
      end
      flp_pkg::ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flp_pkg::ST_IDLE;
      launch_r    <= 1'b0;
      stage_r     <= '0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < flp_pkg::NSTAGES; j++) begin
        pi_r[j] <= '0;
        po_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (mul_done || div_done) begin
        launch_r <= 1'b0;
      end else if (mul_req.start || div_req.start) begin
        launch_r <= 1'b1;
      end
      if (in_acc) begin
        stage_r <= '0;
        if (in_ch.action) begin
          for (int j = 0; j < flp_pkg::NSTAGES; j++) begin
            pi_r[j] <= '0;
            po_r[j] <= '0;
          end
        end
      end
      // Stage state rotates so that the stage at work is always at the head.
      if ((state_r == flp_pkg::ST_MUL_OUT) && mul_done) begin
        stage_r <= stage_r + flp_pkg::STG_W'(1);
        for (int j = 0; j < flp_pkg::NSTAGES - 1; j++) begin
          pi_r[j] <= pi_r[j+1];
          po_r[j] <= po_r[j+1];
        end
        pi_r[flp_pkg::NSTAGES-1] <= u_r;
        po_r[flp_pkg::NSTAGES-1] <= y_new;
      end
      if ((state_r == flp_pkg::ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_ch.audio_in;
      if (in_ch.cutoff_hz > flp_pkg::CUTOFF_W'(flp_pkg::CUTOFF_MAX)) begin
        fc_r <= flp_pkg::FC_W'(flp_pkg::CUTOFF_MAX);
      end else begin
        fc_r <= in_ch.cutoff_hz[flp_pkg::FC_W-1:0];
      end
      if (in_ch.resonance < 0) begin
        kc_r <= '0;
      end else if (in_ch.resonance > flp_pkg::RES_W'(flp_pkg::RES_MAX)) begin
        kc_r <= flp_pkg::RES_W'(flp_pkg::RES_MAX);
      end else begin
        kc_r <= in_ch.resonance;
      end
    end
    if ((state_r == flp_pkg::ST_DIV_RED) && div_done) begin
      kc_r <= kc_r - flp_pkg::RES_W'(div_quot);
    end
    if ((state_r == flp_pkg::ST_DIV_PT) && div_done) begin
      ptq_r <= div_quot[flp_pkg::PTQ_W-1:0];
    end
    if ((state_r == flp_pkg::ST_MUL_PT1) && mul_done) begin
      pt1_r <= mul_p[flp_pkg::COEF_FRAC +: BW];
      npt_r <= BW'(flp_pkg::Q16_ONE) - BW'(ptq_r);
    end
    if ((state_r == flp_pkg::ST_MUL_FB) && mul_done) begin
      u_r <= u_fb;
    end
    if ((state_r == flp_pkg::ST_MUL_PREV) && mul_done) begin
      t_r <= t_new;
    end
    if ((state_r == flp_pkg::ST_MUL_OUT) && mul_done) begin
      u_r <= y_new;
    end
    if ((state_r == flp_pkg::ST_OUT) && out_free) begin
      out_data_r <= sat_sample(out_rnd);
    end
  end

  assign in_ch.ready      = in_ready;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.audio_out = out_data_r;

endmodule
`default_nettype wire
